// ===== hdl/dept_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dept_pkg
// Shared types and constants of the directional extreme point tracker.
// ----------------------------------------------------------------------------
package dept_pkg;

  localparam int NUM_DIRECTIONS_DEF = 64;
  localparam int COORD_BITS_DEF     = 16;

  localparam int CMD_BITS = 2;
  localparam int IDX_BITS = 6;
  localparam int CFG_BITS = 7;

  localparam logic [CFG_BITS-1:0] ACTIVE_RESET = 7'd64;

  localparam logic [CMD_BITS-1:0] CMD_LOAD = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_ADD  = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_READ = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SWEEP,
    S_DRAIN,
    S_READ,
    S_DONE
  } dept_state_t;

endpackage : dept_pkg
`default_nettype wire

// ===== hdl/dept_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dept_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module dept_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire  logic                                      clk,
  input  wire  logic                                      we,
  input  wire  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire  logic [WIDTH-1:0]                          wdata,
  input  wire  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic       [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : dept_ram
`default_nettype wire

// ===== hdl/dept_dot.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dept_dot
// Two-stage signed 3D dot product: products registered, then summed.
// ----------------------------------------------------------------------------
module dept_dot #(
  parameter int COORD_BITS = 16
) (
  input  wire  logic                             clk,
  input  wire  logic                             rst,
  input  wire  logic                             in_vld,
  input  wire  logic signed [COORD_BITS-1:0]     dir_x,
  input  wire  logic signed [COORD_BITS-1:0]     dir_y,
  input  wire  logic signed [COORD_BITS-1:0]     dir_z,
  input  wire  logic signed [COORD_BITS-1:0]     pt_x,
  input  wire  logic signed [COORD_BITS-1:0]     pt_y,
  input  wire  logic signed [COORD_BITS-1:0]     pt_z,
  output logic                                   busy,
  output logic                                   out_vld,
  output logic signed [2*COORD_BITS+1:0]         dot
);

  localparam int PB = 2 * COORD_BITS;
  localparam int SB = PB + 2;

  logic signed [PB-1:0] prod_x;
  logic signed [PB-1:0] prod_y;
  logic signed [PB-1:0] prod_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      busy    <= in_vld;
      out_vld <= busy;
    end
  end

  always_ff @(posedge clk) begin
    prod_x <= dir_x * pt_x;
    prod_y <= dir_y * pt_y;
    prod_z <= dir_z * pt_z;
    dot    <= SB'(prod_x) + SB'(prod_y) + SB'(prod_z);
  end

endmodule : dept_dot
`default_nettype wire

// ===== hdl/directional_extreme_point_tracker_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// directional_extreme_point_tracker_unit
// Direction table plus per-direction support point, updated by streamed points.
// ----------------------------------------------------------------------------
// Sequence: load and unused command go from accept to the result; read entry passes
//   a read state; add point sweeps n = min(active_directions, NUM_DIRECTIONS) entries.
// Throughput: one item at a time; add point is set by the entry sweep, which
//   feeds one direction per cycle through the shared dot product unit.
// Reset: active_directions = 64, all directions zero, all entries empty.
//   No clearing pass; the RAMs are guarded by per-entry flag flops.
// ----------------------------------------------------------------------------
module directional_extreme_point_tracker_unit #(
  parameter int NUM_DIRECTIONS = dept_pkg::NUM_DIRECTIONS_DEF,
  parameter int COORD_BITS     = dept_pkg::COORD_BITS_DEF
) (
  input  wire  logic                               clk,
  input  wire  logic                               rst,
  // configuration write channel
  input  wire  logic                               cfg_valid,
  output logic                                     cfg_ready,
  input  wire  logic [dept_pkg::CFG_BITS-1:0]      cfg_data,
  // request channel
  input  wire  logic                               req_valid,
  output logic                                     req_ready,
  input  wire  logic [dept_pkg::CMD_BITS-1:0]      command,
  input  wire  logic [dept_pkg::IDX_BITS-1:0]      entry_index,
  input  wire  logic signed [COORD_BITS-1:0]       coord_x,
  input  wire  logic signed [COORD_BITS-1:0]       coord_y,
  input  wire  logic signed [COORD_BITS-1:0]       coord_z,
  // response channel
  output logic                                     rsp_valid,
  input  wire  logic                               rsp_ready,
  output logic                                     hull_changed,
  output logic                                     entry_valid,
  output logic signed [COORD_BITS-1:0]             best_x,
  output logic signed [COORD_BITS-1:0]             best_y,
  output logic signed [COORD_BITS-1:0]             best_z
);

  import dept_pkg::*;

  localparam int IW = (NUM_DIRECTIONS > 1) ? $clog2(NUM_DIRECTIONS) : 1;
  localparam int CW = $clog2(NUM_DIRECTIONS + 1);   // sweep counter, holds n
  localparam int PW = 2 * COORD_BITS + 2;           // exact dot product width
  localparam int DW = 3 * COORD_BITS;               // direction word
  localparam int EW = 3 * COORD_BITS + PW;          // point word + projection

  // --------------------------------------------------------------------------
  // Control state
  // --------------------------------------------------------------------------
  dept_state_t state, state_next;

  logic [CFG_BITS-1:0]       active_directions;
  logic [NUM_DIRECTIONS-1:0] dir_loaded;          // 0 -> direction reads as zero
  logic [NUM_DIRECTIONS-1:0] entry_valid_bits;    // entry holds a point
  logic [CW-1:0]             cnt;
  logic [CW-1:0]             n_eff;
  logic                      chg;

  // request payload held for the duration of the item
  logic [IW-1:0]                  req_idx;
  logic                           req_ok;
  logic signed [COORD_BITS-1:0]   req_x, req_y, req_z;

  // read-entry result
  logic                           rd_ev;
  logic signed [COORD_BITS-1:0]   rd_x, rd_y, rd_z;

  logic req_acc;
  logic idx_ok;
  logic [IW-1:0] in_addr;
  logic issue;
  logic rsp_load;
  logic [8:0] act9;

  assign req_acc = req_valid && req_ready;
  assign idx_ok  = (9'(entry_index) < 9'(NUM_DIRECTIONS));
  assign in_addr = IW'(entry_index);
  assign act9    = 9'(active_directions);
  // saturate active count to the table size
  assign n_eff   = (act9 > 9'(NUM_DIRECTIONS)) ? CW'(NUM_DIRECTIONS) : CW'(act9);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_directions <= ACTIVE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      active_directions <= cfg_data;
    end
  end

  // --------------------------------------------------------------------------
  // Tables: direction RAM and point/projection RAM
  // --------------------------------------------------------------------------
  logic          dir_we;
  logic [DW-1:0] dir_rdata;
  logic          pt_we;
  logic [IW-1:0] pt_waddr;
  logic [EW-1:0] pt_wdata;
  logic [EW-1:0] pt_rdata;
  logic [IW-1:0] rd_addr;

  assign dir_we  = req_acc && (command == CMD_LOAD) && idx_ok;
  // accept cycle issues the read-entry access, otherwise the sweep address
  assign rd_addr = (state == S_IDLE) ? in_addr : cnt[IW-1:0];

  dept_ram #(
    .WIDTH (DW),
    .DEPTH (NUM_DIRECTIONS)
  ) u_dir_ram (
    .clk   (clk),
    .we    (dir_we),
    .waddr (in_addr),
    .wdata ({coord_x, coord_y, coord_z}),
    .raddr (rd_addr),
    .rdata (dir_rdata)
  );

  dept_ram #(
    .WIDTH (EW),
    .DEPTH (NUM_DIRECTIONS)
  ) u_pt_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (pt_waddr),
    .wdata (pt_wdata),
    .raddr (rd_addr),
    .rdata (pt_rdata)
  );

  // --------------------------------------------------------------------------
  // Sweep pipeline: issue -> RAM read (s1) -> products -> sum (s3) -> update
  // --------------------------------------------------------------------------
  logic                         s1_vld;
  logic [IW-1:0]                s1_idx, s2_idx, s3_idx;
  logic                         s2_ev, s3_ev;
  logic signed [PW-1:0]         s2_proj, s3_proj;
  logic signed [COORD_BITS-1:0] s1_dx, s1_dy, s1_dz;
  logic                         s1_loaded;
  logic                         dot_busy;
  logic                         dot_vld;
  logic signed [PW-1:0]         dot;
  logic                         take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= issue;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx  <= cnt[IW-1:0];
    s2_idx  <= s1_idx;
    s3_idx  <= s2_idx;
    s2_ev   <= entry_valid_bits[s1_idx];
    s3_ev   <= s2_ev;
    s2_proj <= pt_rdata[PW-1:0];
    s3_proj <= s2_proj;
  end

  // an unloaded direction is the zero vector
  assign s1_loaded = dir_loaded[s1_idx];
  assign s1_dx = s1_loaded ? dir_rdata[DW-1 -: COORD_BITS]           : '0;
  assign s1_dy = s1_loaded ? dir_rdata[2*COORD_BITS-1 -: COORD_BITS] : '0;
  assign s1_dz = s1_loaded ? dir_rdata[COORD_BITS-1:0]               : '0;

  dept_dot #(
    .COORD_BITS (COORD_BITS)
  ) u_dot (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (s1_vld),
    .dir_x   (s1_dx),
    .dir_y   (s1_dy),
    .dir_z   (s1_dz),
    .pt_x    (req_x),
    .pt_y    (req_y),
    .pt_z    (req_z),
    .busy    (dot_busy),
    .out_vld (dot_vld),
    .dot     (dot)
  );

  // empty entry takes anything; ties keep the old point
  assign take     = dot_vld && (!s3_ev || (dot > s3_proj));
  assign pt_we    = take;
  assign pt_waddr = s3_idx;
  assign pt_wdata = {req_x, req_y, req_z, dot};

  // --------------------------------------------------------------------------
  // Per-entry flags, counter, payload and result registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      dir_loaded       <= '0;
      entry_valid_bits <= '0;
      cnt              <= '0;
      chg              <= 1'b0;
    end else begin
      if (dir_we) begin
        dir_loaded[in_addr]       <= 1'b1;
        entry_valid_bits[in_addr] <= 1'b0;
      end
      if (take) begin
        entry_valid_bits[s3_idx] <= 1'b1;
        chg                      <= 1'b1;
      end else if (req_acc) begin
        chg <= 1'b0;
      end
      if (req_acc) begin
        cnt <= '0;
      end else if (issue) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_acc) begin
      req_idx <= in_addr;
      req_ok  <= idx_ok;
      req_x   <= coord_x;
      req_y   <= coord_y;
      req_z   <= coord_z;
      rd_ev   <= 1'b0;
      rd_x    <= '0;
      rd_y    <= '0;
      rd_z    <= '0;
    end else if (state == S_READ && req_ok && entry_valid_bits[req_idx]) begin
      rd_ev <= 1'b1;
      rd_x  <= pt_rdata[EW-1 -: COORD_BITS];
      rd_y  <= pt_rdata[EW-COORD_BITS-1 -: COORD_BITS];
      rd_z  <= pt_rdata[PW+COORD_BITS-1 -: COORD_BITS];
    end
  end

  // output register: the next item is taken while a result waits here
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      hull_changed <= chg;
      entry_valid  <= rd_ev;
      best_x       <= rd_x;
      best_y       <= rd_y;
      best_z       <= rd_z;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_acc) begin
          case (command)
            CMD_ADD:  state_next = S_SWEEP;
            CMD_READ: state_next = S_READ;
            default:  state_next = S_DONE;
          endcase
        end
      end
      S_SWEEP: begin
        if (cnt == n_eff) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!s1_vld && !dot_busy && !dot_vld) begin
          state_next = S_DONE;
        end
      end
      S_READ:  state_next = S_DONE;
      S_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    issue     = 1'b0;
    rsp_load  = 1'b0;
    case (state)
      S_IDLE:  req_ready = 1'b1;
      S_SWEEP: issue     = (cnt != n_eff);
      S_DONE:  rsp_load  = !rsp_valid || rsp_ready;
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_resp_kind : assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(hull_changed && entry_valid))
    else $error("add and read flags set in one item");

  a_pt_write_in_sweep : assert property (@(posedge clk) disable iff (rst)
    pt_we |-> (state == S_SWEEP || state == S_DRAIN))
    else $error("point table written outside a sweep");

  a_cnt_bound : assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP) |-> (cnt <= n_eff))
    else $error("sweep counter passed the active count");

  a_load_empties : assert property (@(posedge clk) disable iff (rst)
    dir_we |=> (dir_loaded[$past(in_addr)] && !entry_valid_bits[$past(in_addr)]))
    else $error("loaded entry not emptied");

  a_drain_done : assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> (!s1_vld && !dot_busy && !dot_vld))
    else $error("result issued with sweep still in flight");

endmodule : directional_extreme_point_tracker_unit
`default_nettype wire
